FILE: hw/rtl/mmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mmf_pkg: shared definitions of the multichannel median filter
// Field widths, parameter defaults, word layouts, controller states and the
// command bundle from the controller to the datapath.
// ============================================================================
package mmf_pkg;

   localparam int FIELDS              = 8;
   localparam int FIELD_BITS          = 12;
   localparam int WINDOW_DEFAULT      = 11;
   localparam int CHANNELS_DEFAULT    = 8;
   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int WINDOW_MAX          = 31;
   localparam int SLOT_BITS           = $clog2(WINDOW_MAX);

   typedef logic [FIELD_BITS-1:0] field_type;

   typedef struct packed {
      field_type reading_7;
      field_type reading_6;
      field_type reading_5;
      field_type reading_4;
      field_type reading_3;
      field_type reading_2;
      field_type reading_1;
      field_type reading_0;
   } mmf_req_data_type;

   typedef struct packed {
      field_type median_7;
      field_type median_6;
      field_type median_5;
      field_type median_4;
      field_type median_3;
      field_type median_2;
      field_type median_1;
      field_type median_0;
   } mmf_rsp_data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } mmf_state_type;

   // The datapath's work for each cycle. Read results come back in the next cycle,
   // so the datapath delays the read flags to line up with the data.
   typedef struct packed {
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_slot;
      logic [SLOT_BITS-1:0] rd_slot;
      logic                 rd_load;
      logic                 rd_compare;
      logic                 rd_last;
      logic                 publish;
   } mmf_cmd_type;

endpackage : mmf_pkg
`default_nettype wire

FILE: hw/rtl/mmf_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mmf_req_if: scan channel into the median filter
// Valid/ready handshake carrying one scan of sensor readings per word.
// ============================================================================
interface mmf_req_if;
   import mmf_pkg::*;

   logic             valid;
   logic             ready;
   mmf_req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface : mmf_req_if
`default_nettype wire

FILE: hw/rtl/mmf_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mmf_rsp_if: median channel out of the median filter
// Valid/ready handshake carrying one set of channel medians per word.
// ============================================================================
interface mmf_rsp_if;
   import mmf_pkg::*;

   logic             valid;
   logic             ready;
   mmf_rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface : mmf_rsp_if
`default_nettype wire

FILE: hw/rtl/mmf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mmf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module mmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : mmf_ram
`default_nettype wire

FILE: hw/rtl/mmf_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mmf_controller: sequencer of the median filter
// Stores each scan, then walks every ring row as a candidate and, for each
// candidate, reads every ring row once to rank it, then offers the result.
// ============================================================================
module mmf_controller import mmf_pkg::*; #(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      mmf_cmd_type cmd
);

   localparam int AW = $clog2(WINDOW);
   localparam logic [AW-1:0] LAST_ROW = AW'(WINDOW - 1);

   mmf_state_type state_ff, state_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [AW-1:0] cand_ff, cand_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Next state and counters.
   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      cand_in  = cand_ff;
      scan_in  = scan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               slot_in  = (slot_ff == LAST_ROW) ? '0 : slot_ff + AW'(1);
               cand_in  = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            scan_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_ff == LAST_ROW) begin
               if (cand_ff == LAST_ROW) begin
                  state_in = ST_DRAIN;
               end else begin
                  cand_in  = cand_ff + AW'(1);
                  state_in = ST_LOAD;
               end
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.wr_en   = req_valid;
            cmd.wr_slot = SLOT_BITS'(slot_ff);
         end
         ST_LOAD: begin
            cmd.rd_slot = SLOT_BITS'(cand_ff);
            cmd.rd_load = 1'b1;
         end
         ST_SCAN: begin
            cmd.rd_slot    = SLOT_BITS'(scan_ff);
            cmd.rd_compare = 1'b1;
            cmd.rd_last    = (scan_ff == LAST_ROW);
         end
         ST_DRAIN: begin
            cmd.publish = 1'b0;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         cand_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         cand_ff      <= cand_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : mmf_controller
`default_nettype wire

FILE: hw/rtl/mmf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mmf_datapath: sample ring and rank counters of the median filter
// Holds the ring of scans, ranks a candidate against every row in all
// channels at once, and keeps the median and the output word.
// ============================================================================
module mmf_datapath import mmf_pkg::*; #(
   parameter int WINDOW      = WINDOW_DEFAULT,
   parameter int CHANNELS    = CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mmf_cmd_type      cmd,
   input  wire mmf_req_data_type req_data,
   output      mmf_rsp_data_type rsp_data
);

   localparam int AW  = $clog2(WINDOW);
   localparam int CW  = $clog2(WINDOW + 1);
   localparam int MID = WINDOW / 2;
   localparam int RW  = CHANNELS * SAMPLE_BITS;
   localparam int EW  = FIELD_BITS + SAMPLE_BITS;

   field_type        reading [FIELDS];
   field_type        out_field [FIELDS];
   logic [RW-1:0]    wr_row;
   logic [RW-1:0]    rd_row;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr;

   logic [WINDOW-1:0] row_valid_ff, row_valid_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              load_ff, load_in;
   logic              compare_ff, compare_in;
   logic              last_ff, last_in;

   logic [SAMPLE_BITS-1:0] sample    [CHANNELS];
   logic [SAMPLE_BITS-1:0] cand_ff   [CHANNELS];
   logic [SAMPLE_BITS-1:0] cand_in   [CHANNELS];
   logic [SAMPLE_BITS-1:0] median_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] median_in [CHANNELS];
   logic [CW-1:0]          less_ff   [CHANNELS];
   logic [CW-1:0]          less_in   [CHANNELS];
   logic [CW-1:0]          leq_ff    [CHANNELS];
   logic [CW-1:0]          leq_in    [CHANNELS];
   logic [CW-1:0]          less_sum  [CHANNELS];
   logic [CW-1:0]          leq_sum   [CHANNELS];

   mmf_rsp_data_type rsp_data_ff, rsp_data_in;

   assign reading[0] = req_data.reading_0;
   assign reading[1] = req_data.reading_1;
   assign reading[2] = req_data.reading_2;
   assign reading[3] = req_data.reading_3;
   assign reading[4] = req_data.reading_4;
   assign reading[5] = req_data.reading_5;
   assign reading[6] = req_data.reading_6;
   assign reading[7] = req_data.reading_7;

   assign wr_addr = cmd.wr_slot[AW-1:0];
   assign rd_addr = cmd.rd_slot[AW-1:0];

   // Samples are cut or zero-extended to the stored width.
   always_comb begin
      logic [EW-1:0] ext;
      wr_row = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         ext = EW'(reading[ch]);
         wr_row[ch*SAMPLE_BITS +: SAMPLE_BITS] = ext[SAMPLE_BITS-1:0];
      end
   end

   mmf_ram #(
      .WIDTH (RW),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

   // A row that was never written reads as zero.
   always_comb begin
      row_valid_in = row_valid_ff;
      if (cmd.wr_en) begin
         row_valid_in = row_valid_ff | (WINDOW'(1) << wr_addr);
      end
      rd_valid_in = row_valid_ff[rd_addr];
      load_in     = cmd.rd_load;
      compare_in  = cmd.rd_compare;
      last_in     = cmd.rd_last;
   end

   // Rank counting: a candidate is the median when fewer than MID+1 samples
   // lie below it and more than MID lie at or below it.
   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         sample[ch]   = rd_valid_ff ? rd_row[ch*SAMPLE_BITS +: SAMPLE_BITS] : '0;
         less_sum[ch] = less_ff[ch] + CW'(sample[ch] < cand_ff[ch]);
         leq_sum[ch]  = leq_ff[ch] + CW'(sample[ch] <= cand_ff[ch]);
         cand_in[ch]   = load_ff ? sample[ch] : cand_ff[ch];
         less_in[ch]   = less_ff[ch];
         leq_in[ch]    = leq_ff[ch];
         median_in[ch] = median_ff[ch];
         if (load_ff) begin
            less_in[ch] = '0;
            leq_in[ch]  = '0;
         end else if (compare_ff) begin
            less_in[ch] = less_sum[ch];
            leq_in[ch]  = leq_sum[ch];
            if (last_ff && (less_sum[ch] <= CW'(MID)) && (leq_sum[ch] > CW'(MID))) begin
               median_in[ch] = cand_ff[ch];
            end
         end
      end
   end

   // Output word: channels beyond CHANNELS report zero.
   always_comb begin
      logic [EW-1:0] ext;
      for (int f = 0; f < FIELDS; f++) begin
         out_field[f] = '0;
      end
      for (int ch = 0; ch < CHANNELS; ch++) begin
         ext           = EW'(median_ff[ch]);
         out_field[ch] = ext[FIELD_BITS-1:0];
      end
      rsp_data_in = rsp_data_ff;
      if (cmd.publish) begin
         rsp_data_in.median_0 = out_field[0];
         rsp_data_in.median_1 = out_field[1];
         rsp_data_in.median_2 = out_field[2];
         rsp_data_in.median_3 = out_field[3];
         rsp_data_in.median_4 = out_field[4];
         rsp_data_in.median_5 = out_field[5];
         rsp_data_in.median_6 = out_field[6];
         rsp_data_in.median_7 = out_field[7];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         load_ff      <= 1'b0;
         compare_ff   <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= rd_valid_in;
         load_ff      <= load_in;
         compare_ff   <= compare_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         cand_ff[ch]   <= cand_in[ch];
         less_ff[ch]   <= less_in[ch];
         leq_ff[ch]    <= leq_in[ch];
         median_ff[ch] <= median_in[ch];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_data = rsp_data_ff;

endmodule : mmf_datapath
`default_nettype wire

FILE: hw/rtl/multichannel_median_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// multichannel_median_filter: running median of eleven scans, eight channels
// Each scan word is written into a ring of the last WINDOW scans; the block
// then answers the median of every channel over the ring.
// ============================================================================
//
//   Channel  Direction  Handshake      Word contents
//   req_if   in         valid/ready    reading_0 .. reading_7, 12 bits each
//   rsp_if   out        valid/ready    median_0 .. median_7, 12 bits each
//
// A scan word is taken only while the sequencer is idle. The scan is written
// to the ring in the cycle it is taken, then every ring row is ranked against
// every row, one ring read per cycle with all channels compared in parallel.
// Each candidate row is loaded, every row is scanned against it, and after a
// drain state the result is offered; the sequencer then returns to idle, so
// no new scan is taken until the last one's result is in the output register.
// The single ring read port sets the length of the ranking pass.
// Reset is synchronous and leaves the ring reading as all zero through per-row
// valid flags, so the first medians count those zeros; no clearing pass runs.
// The result sits in an output register: a new scan is taken while the last
// result waits, and the finished median is held back until the output drains.
//
module multichannel_median_filter import mmf_pkg::*; #(
   parameter int WINDOW      = WINDOW_DEFAULT,
   parameter int CHANNELS    = CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   mmf_req_if.sink   req_if,
   mmf_rsp_if.source rsp_if
);

   // Command bundle from the sequencer into the ring and rank datapath.
   mmf_cmd_type cmd;

   // The sequencer owns the handshake, the write slot and the rank loops.
   mmf_controller #(
      .WINDOW (WINDOW)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // The datapath holds the ring, the per-channel rank counters and the
   // output word register.
   mmf_datapath #(
      .WINDOW      (WINDOW),
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_if.data),
      .rsp_data (rsp_if.data)
   );

endmodule : multichannel_median_filter
`default_nettype wire

FILE: hw/rtl/mmf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mmf_checker: port-level checks of the median filter
// Watches both handshakes at the top level and is bound to it.
// ============================================================================
module mmf_checker import mmf_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire mmf_rsp_data_type rsp_data
);

   // Taking a scan starts the ranking pass, so no second scan follows at once.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("scan taken in the cycle after a scan was taken");

   // A new result is only offered while the sequencer is idle.
   a_idle_with_result : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("new result offered while the sequencer is busy");

   // No new result is offered right after a scan is taken.
   a_no_instant_result : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared right after a scan was taken");

   // A stalled result keeps its word.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result dropped or changed");

endmodule : mmf_checker

bind multichannel_median_filter mmf_checker u_mmf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);
`default_nettype wire
